// ===== sv/ecpu_pkg.sv =====
// shared types and constants for the eight-bit cpu instruction step block
// no dependencies; used by ecpu_mem, ecpu_rf and the top level
package ecpu_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // item kinds carried on the input tuser
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // port access kinds
    localparam logic [1:0] IO_NONE = 2'd0;
    localparam logic [1:0] IO_OUT  = 2'd1;
    localparam logic [1:0] IO_IN   = 2'd2;

    // opcode groups (high nibble)
    localparam logic [3:0] GRP_LDN  = 4'h0;
    localparam logic [3:0] GRP_INC  = 4'h1;
    localparam logic [3:0] GRP_DEC  = 4'h2;
    localparam logic [3:0] GRP_SBR  = 4'h3;
    localparam logic [3:0] GRP_LDA  = 4'h4;
    localparam logic [3:0] GRP_STR  = 4'h5;
    localparam logic [3:0] GRP_IO   = 4'h6;
    localparam logic [3:0] GRP_MISC = 4'h7;
    localparam logic [3:0] GRP_GLO  = 4'h8;
    localparam logic [3:0] GRP_GHI  = 4'h9;
    localparam logic [3:0] GRP_PLO  = 4'ha;
    localparam logic [3:0] GRP_PHI  = 4'hb;
    localparam logic [3:0] GRP_LBR  = 4'hc;
    localparam logic [3:0] GRP_SEP  = 4'hd;
    localparam logic [3:0] GRP_SEX  = 4'he;
    localparam logic [3:0] GRP_ALU  = 4'hf;

    localparam logic [3:0] MARK_REG = 4'h2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_RD,
        ST_PO,
        ST_PR,
        ST_RES
    } state_t;

    // register file write port
    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [15:0] data;
    } rf_wr_t;

    // memory write port
    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

// ===== sv/ecpu_mem.sv =====
// byte main memory, one write and one registered read per cycle
// depends on ecpu_pkg
module ecpu_mem (
    input  logic                      clk,
    input  ecpu_pkg::mem_wr_t         wr,
    input  logic [ecpu_pkg::MEM_AW-1:0] raddr,
    output logic [7:0]                rdata
);

    logic [7:0] mem [ecpu_pkg::MEM_BYTES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ecpu_rf.sv =====
// sixteen 16-bit pointer registers held in a small synchronous memory
// depends on ecpu_pkg; reset clears all entries through valid bits
module ecpu_rf (
    input  logic               clk,
    input  logic               rst_n,
    input  ecpu_pkg::rf_wr_t   wr,
    input  logic [3:0]         raddr,
    output logic [15:0]        rdata
);

    logic [15:0] regs [16];
    logic [15:0] valid_reg;
    logic [15:0] rd_reg;
    logic        rd_valid_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            regs[wr.addr] <= wr.data;
        end
        rd_reg <= regs[raddr];
    end

    // valid bits so an entry never written reads zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : 16'h0000;

endmodule

// ===== sv/eight_bit_cpu_instruction_step.sv =====
// Eight-bit CPU instruction step core.
// Input channel s_axis: one transfer is one item. tuser carries the item
// kind (execute one instruction, write a memory byte, read a memory byte);
// tdata carries the memory address, write byte, input port byte and the
// four external flags.
// Output channel m_axis: exactly one result transfer per input item, with
// the idle flag and port access kind in tuser and port line, port data,
// read byte, D, DF, Q and R[P] in tdata.
// An execute item passes through fetch (F0, F1), operand reads (F2, F3) and
// execute with write-back (F4), a read item through RD, and every item then
// reads back R[P] (PO, PR) before the result (RES). Each item is a chain of
// reads and write-backs on the byte memory and the pointer register file, both
// single read port memories with registered reads; items go one at a time.
// An input register takes the next item while the current one is in work,
// and the output register holds a finished result while the next item runs.
// If the receiver stalls, the finished result waits in the core until the
// output register is taken.
// Reset clears all CPU registers (D, DF, P, X, T, IE, Q and the pointer
// registers); memory contents are undefined until written.
// depends on ecpu_pkg, ecpu_mem and ecpu_rf
module eight_bit_cpu_instruction_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    // mem_addr[15:0], mem_wdata[23:16], in_byte[31:24], ef_flags[35:32], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // idle[0], io_kind[2:1]
    output logic [2:0]  m_axis_tuser,
    // io_port[2:0], io_data[10:3], read_data[18:11], accumulator[26:19],
    // carry_flag[27], q_flag[28], program_counter[44:29], zero pad
    output logic [47:0] m_axis_tdata
);

    localparam int AW = ecpu_pkg::MEM_AW;

    // input register
    logic        ib_valid_reg;
    logic [1:0]  ib_op_reg;
    logic [15:0] ib_addr_reg;
    logic [7:0]  ib_wdata_reg;
    logic [7:0]  ib_in_reg;
    logic [3:0]  ib_ef_reg;

    // cpu state
    ecpu_pkg::state_t state_reg, state_next;
    logic [7:0]  d_reg, d_next;
    logic        df_reg, df_next;
    logic [3:0]  p_reg, p_next;
    logic [3:0]  x_reg, x_next;
    logic [7:0]  t_reg, t_next;
    logic        ie_reg, ie_next;
    logic        q_reg, q_next;

    // per item working registers
    logic [7:0]  in_reg, in_next;
    logic [3:0]  ef_reg, ef_next;
    logic [7:0]  opc_reg, opc_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] rv_reg, rv_next;
    logic [7:0]  md_reg, md_next;
    logic        idle_res_reg, idle_res_next;
    logic [1:0]  kind_res_reg, kind_res_next;
    logic [2:0]  port_res_reg, port_res_next;
    logic [7:0]  iod_res_reg, iod_res_next;
    logic [7:0]  rd_res_reg, rd_res_next;
    logic [15:0] pco_reg, pco_next;

    // output register
    logic        ov_reg;
    logic [2:0]  ou_reg;
    logic [47:0] od_reg;
    logic        take;
    logic        out_load;

    // memory ports
    ecpu_pkg::mem_wr_t mwr;
    logic [AW-1:0]     mraddr;
    logic [7:0]        mrdata;
    ecpu_pkg::rf_wr_t  rwr;
    logic [3:0]        rraddr;
    logic [15:0]       rrdata;

    // execute helpers
    logic [3:0]  hi, n;
    logic [8:0]  sum;
    logic [7:0]  add_a, add_b;
    logic        add_c;
    logic        cond;

    ecpu_mem u_mem (
        .clk   (clk),
        .wr    (mwr),
        .raddr (mraddr),
        .rdata (mrdata)
    );

    ecpu_rf u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rwr),
        .raddr (rraddr),
        .rdata (rrdata)
    );

    assign s_axis_tready = !ib_valid_reg;
    assign take          = (state_reg == ecpu_pkg::ST_IDLE) && ib_valid_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tdata  = od_reg;
    assign out_load      = (state_reg == ecpu_pkg::ST_RES) && (!ov_reg || m_axis_tready);

    assign hi = opc_reg[7:4];
    assign n  = opc_reg[3:0];

    // branch condition on the low opcode bits
    function automatic logic cond_short(input logic [2:0] k, input logic [3:0] ef,
                                        input logic q, input logic [7:0] d,
                                        input logic df);
        logic r;
        begin
            case (k)
                3'd0:    r = 1'b1;
                3'd1:    r = q;
                3'd2:    r = (d == 8'h00);
                3'd3:    r = df;
                default: r = ef[k[1:0]];
            endcase
            return r;
        end
    endfunction

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            ib_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            ib_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ib_op_reg    <= s_axis_tuser;
            ib_addr_reg  <= s_axis_tdata[15:0];
            ib_wdata_reg <= s_axis_tdata[23:16];
            ib_in_reg    <= s_axis_tdata[31:24];
            ib_ef_reg    <= s_axis_tdata[35:32];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ou_reg <= {kind_res_reg, idle_res_reg};
            od_reg <= {3'b000, pco_reg, q_reg, df_reg, d_reg, rd_res_reg,
                       iod_res_reg, port_res_reg};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecpu_pkg::ST_IDLE;
            d_reg     <= '0;
            df_reg    <= 1'b0;
            p_reg     <= '0;
            x_reg     <= '0;
            t_reg     <= '0;
            ie_reg    <= 1'b0;
            q_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            d_reg     <= d_next;
            df_reg    <= df_next;
            p_reg     <= p_next;
            x_reg     <= x_next;
            t_reg     <= t_next;
            ie_reg    <= ie_next;
            q_reg     <= q_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        ef_reg       <= ef_next;
        opc_reg      <= opc_next;
        idx_reg      <= idx_next;
        rv_reg       <= rv_next;
        md_reg       <= md_next;
        idle_res_reg <= idle_res_next;
        kind_res_reg <= kind_res_next;
        port_res_reg <= port_res_next;
        iod_res_reg  <= iod_res_next;
        rd_res_reg   <= rd_res_next;
        pco_reg      <= pco_next;
    end

    // adder operands for add and subtract instructions
    always_comb
    begin
        add_a = md_reg;
        add_b = d_reg;
        add_c = df_reg;
        if (hi == ecpu_pkg::GRP_MISC)
        begin
            case (n[1:0])
                2'b01:   add_b = ~d_reg;
                2'b11:
                begin
                    add_a = d_reg;
                    add_b = ~md_reg;
                end
                default: add_b = d_reg;
            endcase
        end
        else
        begin
            case (n[2:0])
                3'd4:    add_c = 1'b0;
                3'd5:
                begin
                    add_b = ~d_reg;
                    add_c = 1'b1;
                end
                default:
                begin
                    add_a = d_reg;
                    add_b = ~md_reg;
                    add_c = 1'b1;
                end
            endcase
        end
        sum  = {1'b0, add_a} + {1'b0, add_b} + {8'h00, add_c};
        cond = cond_short(n[2:0], ef_reg, q_reg, d_reg, df_reg);
    end

    // sequencer: fetch, operand reads, execute and write back
    always_comb
    begin
        state_next    = state_reg;
        d_next        = d_reg;
        df_next       = df_reg;
        p_next        = p_reg;
        x_next        = x_reg;
        t_next        = t_reg;
        ie_next       = ie_reg;
        q_next        = q_reg;
        in_next       = in_reg;
        ef_next       = ef_reg;
        opc_next      = opc_reg;
        idx_next      = idx_reg;
        rv_next       = rv_reg;
        md_next       = md_reg;
        idle_res_next = idle_res_reg;
        kind_res_next = kind_res_reg;
        port_res_next = port_res_reg;
        iod_res_next  = iod_res_reg;
        rd_res_next   = rd_res_reg;
        pco_next      = pco_reg;
        mwr           = '0;
        mraddr        = ib_addr_reg[AW-1:0];
        rwr           = '0;
        rraddr        = p_reg;

        unique case (state_reg)
            ecpu_pkg::ST_IDLE:
            begin
                idle_res_next = 1'b0;
                kind_res_next = ecpu_pkg::IO_NONE;
                port_res_next = '0;
                iod_res_next  = '0;
                rd_res_next   = '0;
                // keep the item's port byte and flags, the input register refills
                in_next       = ib_in_reg;
                ef_next       = ib_ef_reg;
                if (ib_valid_reg)
                begin
                    case (ib_op_reg)
                        ecpu_pkg::OP_EXEC:  state_next = ecpu_pkg::ST_F0;
                        ecpu_pkg::OP_WRITE:
                        begin
                            mwr.we     = 1'b1;
                            mwr.addr   = ib_addr_reg[AW-1:0];
                            mwr.data   = ib_wdata_reg;
                            state_next = ecpu_pkg::ST_PO;
                        end
                        ecpu_pkg::OP_READ:  state_next = ecpu_pkg::ST_RD;
                        default:            state_next = ecpu_pkg::ST_PO;
                    endcase
                end
            end

            ecpu_pkg::ST_RD:
            begin
                rd_res_next = mrdata;
                state_next  = ecpu_pkg::ST_PO;
            end

            // opcode fetch and program counter advance
            ecpu_pkg::ST_F0:
            begin
                mraddr     = rrdata[AW-1:0];
                rwr.we     = 1'b1;
                rwr.addr   = p_reg;
                rwr.data   = rrdata + 16'd1;
                state_next = ecpu_pkg::ST_F1;
            end

            // pick the operand register
            ecpu_pkg::ST_F1:
            begin
                opc_next = mrdata;
                case (mrdata[7:4])
                    ecpu_pkg::GRP_IO:   idx_next = x_reg;
                    ecpu_pkg::GRP_MISC:
                    begin
                        if (mrdata[3:0] == 4'h9)
                        begin
                            idx_next = ecpu_pkg::MARK_REG;
                        end
                        else if (mrdata[3:2] == 2'b11)
                        begin
                            idx_next = p_reg;
                        end
                        else
                        begin
                            idx_next = x_reg;
                        end
                    end
                    ecpu_pkg::GRP_SBR,
                    ecpu_pkg::GRP_LBR:  idx_next = p_reg;
                    ecpu_pkg::GRP_ALU:  idx_next = mrdata[3] ? p_reg : x_reg;
                    default:            idx_next = mrdata[3:0];
                endcase
                rraddr     = idx_next;
                state_next = ecpu_pkg::ST_F2;
            end

            // operand register value, read the byte it points at
            ecpu_pkg::ST_F2:
            begin
                rv_next    = rrdata;
                mraddr     = rrdata[AW-1:0];
                state_next = ecpu_pkg::ST_F3;
            end

            // second byte for long branches
            ecpu_pkg::ST_F3:
            begin
                md_next    = mrdata;
                mraddr     = AW'(rv_reg + 16'd1);
                state_next = ecpu_pkg::ST_F4;
            end

            // execute and write back
            ecpu_pkg::ST_F4:
            begin
                state_next = ecpu_pkg::ST_PO;
                rwr.addr   = idx_reg;
                rwr.data   = rv_reg;
                mwr.addr   = rv_reg[AW-1:0];
                mwr.data   = d_reg;
                if (opc_reg == 8'h00)
                begin
                    idle_res_next = 1'b1;
                end
                else
                begin
                    case (hi)
                        ecpu_pkg::GRP_LDN: d_next = md_reg;
                        ecpu_pkg::GRP_INC:
                        begin
                            rwr.we   = 1'b1;
                            rwr.data = rv_reg + 16'd1;
                        end
                        ecpu_pkg::GRP_DEC:
                        begin
                            rwr.we   = 1'b1;
                            rwr.data = rv_reg - 16'd1;
                        end
                        ecpu_pkg::GRP_SBR:
                        begin
                            rwr.we = 1'b1;
                            if (cond ^ n[3])
                            begin
                                rwr.data = {rv_reg[15:8], md_reg};
                            end
                            else
                            begin
                                rwr.data = rv_reg + 16'd1;
                            end
                        end
                        ecpu_pkg::GRP_LDA:
                        begin
                            d_next   = md_reg;
                            rwr.we   = 1'b1;
                            rwr.data = rv_reg + 16'd1;
                        end
                        ecpu_pkg::GRP_STR: mwr.we = 1'b1;
                        ecpu_pkg::GRP_IO:
                        begin
                            if (n == 4'h0)
                            begin
                                rwr.we   = 1'b1;
                                rwr.data = rv_reg + 16'd1;
                            end
                            else if (!n[3])
                            begin
                                kind_res_next = ecpu_pkg::IO_OUT;
                                port_res_next = n[2:0];
                                iod_res_next  = md_reg;
                                rwr.we        = 1'b1;
                                rwr.data      = rv_reg + 16'd1;
                            end
                            else if (n != 4'h8)
                            begin
                                kind_res_next = ecpu_pkg::IO_IN;
                                port_res_next = n[2:0];
                                iod_res_next  = in_reg;
                                mwr.we        = 1'b1;
                                mwr.data      = in_reg;
                                d_next        = in_reg;
                            end
                        end
                        ecpu_pkg::GRP_MISC:
                        begin
                            case (n)
                                4'h0, 4'h1:
                                begin
                                    rwr.we   = 1'b1;
                                    rwr.data = rv_reg + 16'd1;
                                    p_next   = md_reg[3:0];
                                    x_next   = md_reg[7:4];
                                    ie_next  = !n[0];
                                end
                                4'h2:
                                begin
                                    d_next   = md_reg;
                                    rwr.we   = 1'b1;
                                    rwr.data = rv_reg + 16'd1;
                                end
                                4'h3:
                                begin
                                    mwr.we   = 1'b1;
                                    rwr.we   = 1'b1;
                                    rwr.data = rv_reg - 16'd1;
                                end
                                4'h4, 4'h5, 4'h7:
                                begin
                                    d_next  = sum[7:0];
                                    df_next = sum[8];
                                end
                                4'h6:
                                begin
                                    df_next = d_reg[0];
                                    d_next  = {df_reg, d_reg[7:1]};
                                end
                                4'h8:
                                begin
                                    mwr.we   = 1'b1;
                                    mwr.data = t_reg;
                                end
                                4'h9:
                                begin
                                    t_next   = {x_reg, p_reg};
                                    mwr.we   = 1'b1;
                                    mwr.data = {x_reg, p_reg};
                                    x_next   = p_reg;
                                    rwr.we   = 1'b1;
                                    rwr.data = rv_reg - 16'd1;
                                end
                                4'ha:    q_next = 1'b0;
                                4'hb:    q_next = 1'b1;
                                4'he:
                                begin
                                    df_next = d_reg[7];
                                    d_next  = {d_reg[6:0], df_reg};
                                end
                                default:
                                begin
                                    d_next   = sum[7:0];
                                    df_next  = sum[8];
                                    rwr.we   = 1'b1;
                                    rwr.data = rv_reg + 16'd1;
                                end
                            endcase
                        end
                        ecpu_pkg::GRP_GLO: d_next = rv_reg[7:0];
                        ecpu_pkg::GRP_GHI: d_next = rv_reg[15:8];
                        ecpu_pkg::GRP_PLO:
                        begin
                            rwr.we   = 1'b1;
                            rwr.data = {rv_reg[15:8], d_reg};
                        end
                        ecpu_pkg::GRP_PHI:
                        begin
                            rwr.we   = 1'b1;
                            rwr.data = {d_reg, rv_reg[7:0]};
                        end
                        ecpu_pkg::GRP_LBR:
                        begin
                            if (!n[2])
                            begin
                                rwr.we = 1'b1;
                                if (cond_short({1'b0, n[1:0]}, 4'h0, q_reg, d_reg, df_reg)
                                    ^ n[3])
                                begin
                                    rwr.data = {md_reg, mrdata};
                                end
                                else
                                begin
                                    rwr.data = rv_reg + 16'd2;
                                end
                            end
                            else
                            begin
                                rwr.data = rv_reg + 16'd2;
                                if (n == 4'hc)
                                begin
                                    rwr.we = ie_reg;
                                end
                                else if (n != 4'h4)
                                begin
                                    rwr.we = cond_short({1'b0, n[1:0]}, 4'h0, q_reg, d_reg,
                                                        df_reg) ^ !n[3];
                                end
                            end
                        end
                        ecpu_pkg::GRP_SEP: p_next = n;
                        ecpu_pkg::GRP_SEX: x_next = n;
                        default:
                        begin
                            if (n[2:0] == 3'd6)
                            begin
                                if (n[3])
                                begin
                                    df_next = d_reg[7];
                                    d_next  = {d_reg[6:0], 1'b0};
                                end
                                else
                                begin
                                    df_next = d_reg[0];
                                    d_next  = {1'b0, d_reg[7:1]};
                                end
                            end
                            else
                            begin
                                case (n[2:0])
                                    3'd0:    d_next = md_reg;
                                    3'd1:    d_next = d_reg | md_reg;
                                    3'd2:    d_next = d_reg & md_reg;
                                    3'd3:    d_next = d_reg ^ md_reg;
                                    default:
                                    begin
                                        d_next  = sum[7:0];
                                        df_next = sum[8];
                                    end
                                endcase
                                rwr.we   = n[3];
                                rwr.data = rv_reg + 16'd1;
                            end
                        end
                    endcase
                end
            end

            // read back R[P] for the result
            ecpu_pkg::ST_PO:
            begin
                rraddr     = p_reg;
                state_next = ecpu_pkg::ST_PR;
            end

            ecpu_pkg::ST_PR:
            begin
                pco_next   = rrdata;
                state_next = ecpu_pkg::ST_RES;
            end

            ecpu_pkg::ST_RES:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    state_next = ecpu_pkg::ST_IDLE;
                end
            end

            default: state_next = ecpu_pkg::ST_IDLE;
        endcase
    end

endmodule
